### hdl/imc_pkg.sv
// Shared types and constants for the I2C slave motor command block.
// Holds status codes, bus action codes, register indexes and payload structs.
// No dependencies.
`default_nettype none

package imc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned RX_CNT_W   = 3;
  localparam int unsigned TX_CNT_W   = 2;
  localparam int unsigned REPLY_NUM  = 3;

  // Bytes accepted per write before the slave starts to nack.
  localparam int unsigned RX_LIMIT   = 6;
  // Bytes in a read reply.
  localparam int unsigned TX_LEN     = 3;

  // Slave status codes.
  localparam logic [BYTE_W-1:0] ST_SLA_W      = 8'h60;
  localparam logic [BYTE_W-1:0] ST_DATA_RX    = 8'h80;
  localparam logic [BYTE_W-1:0] ST_ARB_SLA_W  = 8'h68;
  localparam logic [BYTE_W-1:0] ST_STOP       = 8'hA0;
  localparam logic [BYTE_W-1:0] ST_DATA_RX_NA = 8'h88;
  localparam logic [BYTE_W-1:0] ST_SLA_R      = 8'hA8;
  localparam logic [BYTE_W-1:0] ST_DATA_TX    = 8'hB8;
  localparam logic [BYTE_W-1:0] ST_LAST_TX    = 8'hC8;
  localparam logic [BYTE_W-1:0] ST_DATA_TX_NA = 8'hC0;
  localparam logic [BYTE_W-1:0] ST_BUS_ERROR  = 8'h00;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LOOP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_0   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_1   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_2   = 8'd3;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_NACK  = 2'd2,
    ACT_RESET = 2'd3
  } bus_action_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bus_status;
    logic [BYTE_W-1:0] rx_data;
  } item_t;

  typedef struct packed {
    logic                        open_loop;
    logic [REPLY_NUM-1:0][BYTE_W-1:0] reply;
  } cfg_t;

  typedef struct packed {
    bus_action_t       bus_action;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              dir_cmd_valid;
    logic              motor_select;
    logic              direction;
    logic              duty_cmd_valid;
    logic [BYTE_W-1:0] duty;
  } result_t;

endpackage

`default_nettype wire

### hdl/imc_channels.sv
// Handshake channel interfaces for the I2C slave motor command block.
// Depends on imc_pkg for field widths.
`default_nettype none

interface imc_in_if;
  logic                              valid;
  logic                              ready;
  logic [imc_pkg::BYTE_W-1:0]        bus_status;
  logic [imc_pkg::BYTE_W-1:0]        rx_data;
  modport source (output valid, output bus_status, output rx_data, input ready);
  modport sink   (input valid, input bus_status, input rx_data, output ready);
endinterface

interface imc_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        bus_action;
  logic                              tx_valid;
  logic [imc_pkg::BYTE_W-1:0]        tx_byte;
  logic                              dir_cmd_valid;
  logic                              motor_select;
  logic                              direction;
  logic                              duty_cmd_valid;
  logic [imc_pkg::BYTE_W-1:0]        duty;
  modport source (output valid, output bus_action, output tx_valid, output tx_byte,
                  output dir_cmd_valid, output motor_select, output direction,
                  output duty_cmd_valid, output duty, input ready);
  modport sink   (input valid, input bus_action, input tx_valid, input tx_byte,
                  input dir_cmd_valid, input motor_select, input direction,
                  input duty_cmd_valid, input duty, output ready);
endinterface

interface imc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [imc_pkg::CFG_IDX_W-1:0]     index;
  logic [imc_pkg::BYTE_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/imc_cfg_regs.sv
// Configuration register file: open-loop flag and the three reply bytes.
// Depends on imc_pkg and the imc_cfg_if interface.
`default_nettype none

module imc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  imc_cfg_if.sink       cfg_ch,
  output imc_pkg::cfg_t cfg
);

  imc_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        imc_pkg::CFG_OPEN_LOOP: cfg_r.open_loop <= cfg_ch.data[0];
        imc_pkg::CFG_REPLY_0:   cfg_r.reply[0]  <= cfg_ch.data;
        imc_pkg::CFG_REPLY_1:   cfg_r.reply[1]  <= cfg_ch.data;
        imc_pkg::CFG_REPLY_2:   cfg_r.reply[2]  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/imc_in_stage.sv
// Input register stage: captures one bus event and holds it until it moves on.
// Depends on imc_pkg and the imc_in_if interface.
`default_nettype none

module imc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  imc_in_if.sink         in_ch,
  input  logic           advance,
  output logic           item_valid,
  output imc_pkg::item_t item
);

  logic           valid_r;
  imc_pkg::item_t item_r;
  logic           take;

  // The stage can take a new event when empty or when its current one leaves.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.bus_status <= in_ch.bus_status;
      item_r.rx_data    <= in_ch.rx_data;
    end
  end

endmodule

`default_nettype wire

### hdl/imc_decode.sv
// Status decoder with the transfer counters and held motor selection.
// Depends on imc_pkg. State is committed when the event moves to the output stage.
`default_nettype none

module imc_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  imc_pkg::item_t   item,
  input  imc_pkg::cfg_t    cfg,
  input  logic             commit,
  output imc_pkg::result_t res
);

  localparam logic [imc_pkg::RX_CNT_W-1:0] RxLimit =
    imc_pkg::RX_CNT_W'(imc_pkg::RX_LIMIT);
  localparam logic [imc_pkg::TX_CNT_W-1:0] TxLen =
    imc_pkg::TX_CNT_W'(imc_pkg::TX_LEN);
  localparam logic [imc_pkg::TX_CNT_W-1:0] TxLast =
    imc_pkg::TX_CNT_W'(imc_pkg::TX_LEN - 1);

  logic [imc_pkg::RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [imc_pkg::TX_CNT_W-1:0] tx_count_r, tx_count_nxt;
  logic                         held_motor_r, held_motor_nxt;
  logic                         held_direction_r, held_direction_nxt;
  logic [imc_pkg::TX_CNT_W-1:0] tx_idx;

  // The reply index sticks at the last entry once the reply has run out.
  assign tx_idx = (tx_count_r > TxLast) ? TxLast : tx_count_r;

  always_comb begin
    res                = '0;
    res.bus_action     = imc_pkg::ACT_NONE;
    rx_count_nxt       = rx_count_r;
    tx_count_nxt       = tx_count_r;
    held_motor_nxt     = held_motor_r;
    held_direction_nxt = held_direction_r;

    unique case (item.bus_status) inside
      imc_pkg::ST_SLA_W: begin
        rx_count_nxt   = '0;
        res.bus_action = imc_pkg::ACT_ACK;
      end
      imc_pkg::ST_DATA_RX: begin
        if (rx_count_r < RxLimit) begin
          if (rx_count_r == '0) begin
            // Bit 1 set picks the left motor, bit 0 set picks forward.
            held_motor_nxt     = !item.rx_data[1];
            held_direction_nxt = !item.rx_data[0];
          end else if (rx_count_r == imc_pkg::RX_CNT_W'(1)) begin
            res.dir_cmd_valid = 1'b1;
            res.motor_select  = held_motor_r;
            res.direction     = held_direction_r;
            if (cfg.open_loop) begin
              res.duty_cmd_valid = 1'b1;
              res.duty           = item.rx_data;
            end
          end
          rx_count_nxt = rx_count_r + imc_pkg::RX_CNT_W'(1);
        end
        res.bus_action = (rx_count_nxt >= RxLimit) ? imc_pkg::ACT_NACK : imc_pkg::ACT_ACK;
      end
      imc_pkg::ST_ARB_SLA_W, imc_pkg::ST_STOP, imc_pkg::ST_DATA_RX_NA,
      imc_pkg::ST_LAST_TX, imc_pkg::ST_DATA_TX_NA: begin
        res.bus_action = imc_pkg::ACT_ACK;
      end
      imc_pkg::ST_SLA_R: begin
        tx_count_nxt   = imc_pkg::TX_CNT_W'(1);
        res.tx_valid   = 1'b1;
        res.tx_byte    = cfg.reply[0];
        res.bus_action = imc_pkg::ACT_ACK;
      end
      imc_pkg::ST_DATA_TX: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = cfg.reply[tx_idx];
        if (tx_count_r < TxLen) begin
          tx_count_nxt = tx_count_r + imc_pkg::TX_CNT_W'(1);
        end
        res.bus_action = (tx_count_nxt >= TxLen) ? imc_pkg::ACT_NACK : imc_pkg::ACT_ACK;
      end
      imc_pkg::ST_BUS_ERROR: begin
        res.bus_action = imc_pkg::ACT_RESET;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r       <= '0;
      tx_count_r       <= '0;
      held_motor_r     <= 1'b0;
      held_direction_r <= 1'b0;
    end else if (commit) begin
      rx_count_r       <= rx_count_nxt;
      tx_count_r       <= tx_count_nxt;
      held_motor_r     <= held_motor_nxt;
      held_direction_r <= held_direction_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/imc_out_stage.sv
// Result register stage: holds one decoded answer until the sink takes it.
// Depends on imc_pkg and the imc_out_if interface.
`default_nettype none

module imc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  imc_pkg::result_t res,
  output logic             free,
  imc_out_if.source        out_ch
);

  logic             valid_r;
  imc_pkg::result_t res_r;

  // Free when empty or when the held result is being taken this cycle.
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.bus_action     = res_r.bus_action;
  assign out_ch.tx_valid       = res_r.tx_valid;
  assign out_ch.tx_byte        = res_r.tx_byte;
  assign out_ch.dir_cmd_valid  = res_r.dir_cmd_valid;
  assign out_ch.motor_select   = res_r.motor_select;
  assign out_ch.direction      = res_r.direction;
  assign out_ch.duty_cmd_valid = res_r.duty_cmd_valid;
  assign out_ch.duty           = res_r.duty;

endmodule

`default_nettype wire

### hdl/i2c_slave_motor_command.sv
// I2C slave motor command handler: one bus event in, one bus answer out per event.
// Depends on imc_pkg, the channel interfaces, imc_cfg_regs, imc_in_stage,
// imc_decode and imc_out_stage.
//
// Each transfer on the input channel carries one slave status code with its
// received byte, and produces exactly one transfer on the result channel with
// the bus action to take next, any byte to load for sending and any motor
// commands. On a master write the first data byte chooses the motor and the
// direction, and the second byte issues a direction command for that motor,
// together with a duty command carrying the byte when open-loop mode is set;
// bytes beyond the receive limit are nacked and otherwise ignored. On a master
// read the three reply registers are sent in turn, the last one with a nack,
// and further reads repeat the last reply byte. A bus error status asks for the
// bus logic to be reset, and unknown status codes give no action. The block
// accepts one event per clock cycle while the result channel is ready: an
// event is held in an input register, decoded by a single level of logic and
// written to a result register, which drives the result channel. A result
// waiting on a stalled sink lets one further event wait in the input register,
// after which the input channel stalls too. Configuration writes are taken
// in any cycle and should only be made while no event is in flight.
`default_nettype none

module i2c_slave_motor_command (
  input  logic      clk,
  input  logic      rst_n,
  imc_in_if.sink    in_ch,
  imc_out_if.source out_ch,
  imc_cfg_if.sink   cfg_ch
);

  imc_pkg::cfg_t    cfg;
  imc_pkg::item_t   item;
  imc_pkg::result_t res;
  logic             item_valid;
  logic             out_free;
  logic             advance;

  // An event moves to the result register, and its effect on the counters is
  // committed, in the same cycle.
  assign advance = item_valid && out_free;

  imc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  imc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  imc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .cfg    (cfg),
    .commit (advance),
    .res    (res)
  );

  imc_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### tb/imc_answer_checker.sv
`timescale 1ns / 1ps
// Answer checker for the I2C slave motor command testbench: predicts the answer
// to every bus event and compares it with the block's result transfers.
// Depends on imc_pkg and the channel interfaces in imc_channels.

module imc_answer_checker (
  input  logic clk,
  input  logic rst_n,
  imc_in_if    event_mon,
  imc_out_if   answer_mon,
  imc_cfg_if   reg_mon,
  output int   mismatch_count,
  output int   answers_outstanding
);
  import imc_pkg::*;

  logic                open_loop_q;
  logic [BYTE_W-1:0]   reply_q [REPLY_NUM];
  logic [RX_CNT_W-1:0] rx_cnt;
  logic                held_motor;
  logic                held_dir;
  logic [TX_CNT_W-1:0] tx_cnt;
  result_t             awaited_answers [$];

  // Reads past the end of the reply repeat its last byte.
  function automatic logic [BYTE_W-1:0] reply_entry(logic [TX_CNT_W-1:0] idx);
    int unsigned pick;
    pick = 32'(idx);
    if (pick > TX_LEN - 1) pick = TX_LEN - 1;
    if (pick > REPLY_NUM - 1) pick = REPLY_NUM - 1;
    return reply_q[pick];
  endfunction

  function automatic result_t predict_answer(logic [BYTE_W-1:0] status,
                                             logic [BYTE_W-1:0] data);
    result_t ans;
    ans = '0;
    ans.bus_action = ACT_NONE;
    case (status)
      ST_SLA_W: begin
        rx_cnt = '0;
        ans.bus_action = ACT_ACK;
      end
      ST_DATA_RX: begin
        if (rx_cnt < RX_LIMIT) begin
          if (rx_cnt == 0) begin
            // Bit 1 set picks the left motor, bit 0 set picks forward.
            held_motor = ~data[1];
            held_dir   = ~data[0];
          end else if (rx_cnt == 1) begin
            ans.dir_cmd_valid = 1'b1;
            ans.motor_select  = held_motor;
            ans.direction     = held_dir;
            if (open_loop_q) begin
              ans.duty_cmd_valid = 1'b1;
              ans.duty           = data;
            end
          end
          rx_cnt = rx_cnt + 1'b1;
        end
        ans.bus_action = (rx_cnt >= RX_LIMIT) ? ACT_NACK : ACT_ACK;
      end
      ST_ARB_SLA_W, ST_STOP, ST_DATA_RX_NA, ST_LAST_TX, ST_DATA_TX_NA: begin
        ans.bus_action = ACT_ACK;
      end
      ST_SLA_R: begin
        tx_cnt = TX_CNT_W'(1);
        ans.tx_valid   = 1'b1;
        ans.tx_byte    = reply_entry('0);
        ans.bus_action = ACT_ACK;
      end
      ST_DATA_TX: begin
        ans.tx_valid = 1'b1;
        ans.tx_byte  = reply_entry(tx_cnt);
        if (tx_cnt < TX_LEN) tx_cnt = tx_cnt + 1'b1;
        ans.bus_action = (tx_cnt >= TX_LEN) ? ACT_NACK : ACT_ACK;
      end
      ST_BUS_ERROR: begin
        ans.bus_action = ACT_RESET;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t seen;
    if (!rst_n) begin
      open_loop_q = 1'b0;
      for (int i = 0; i < REPLY_NUM; i++) reply_q[i] = '0;
      rx_cnt     = '0;
      held_motor = 1'b0;
      held_dir   = 1'b0;
      tx_cnt     = '0;
      awaited_answers.delete();
      answers_outstanding <= 0;
    end else begin
      if (reg_mon.valid && reg_mon.ready) begin
        case (reg_mon.index)
          CFG_OPEN_LOOP: open_loop_q = reg_mon.data[0];
          CFG_REPLY_0:   reply_q[0]  = reg_mon.data;
          CFG_REPLY_1:   reply_q[1]  = reg_mon.data;
          CFG_REPLY_2:   reply_q[2]  = reg_mon.data;
          default: begin
          end
        endcase
      end

      if (answer_mon.valid && answer_mon.ready) begin
        seen.bus_action     = bus_action_t'(answer_mon.bus_action);
        seen.tx_valid       = answer_mon.tx_valid;
        seen.tx_byte        = answer_mon.tx_byte;
        seen.dir_cmd_valid  = answer_mon.dir_cmd_valid;
        seen.motor_select   = answer_mon.motor_select;
        seen.direction      = answer_mon.direction;
        seen.duty_cmd_valid = answer_mon.duty_cmd_valid;
        seen.duty           = answer_mon.duty;
        if (awaited_answers.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result transfer with no answer awaited", $realtime);
          mismatch_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (seen.bus_action !== want.bus_action || seen.tx_valid !== want.tx_valid ||
              seen.tx_byte !== want.tx_byte || seen.dir_cmd_valid !== want.dir_cmd_valid ||
              seen.motor_select !== want.motor_select ||
              seen.direction !== want.direction ||
              seen.duty_cmd_valid !== want.duty_cmd_valid || seen.duty !== want.duty) begin
            if (mismatch_count < 10) begin
              $display("%0t: wrong answer, expected act %0d tx %b/%h dir %b/%b/%b duty %b/%h",
                       $realtime, want.bus_action, want.tx_valid, want.tx_byte,
                       want.dir_cmd_valid, want.motor_select, want.direction,
                       want.duty_cmd_valid, want.duty);
              $display("%0t:                 actual act %0d tx %b/%h dir %b/%b/%b duty %b/%h",
                       $realtime, seen.bus_action, seen.tx_valid, seen.tx_byte,
                       seen.dir_cmd_valid, seen.motor_select, seen.direction,
                       seen.duty_cmd_valid, seen.duty);
            end
            mismatch_count++;
          end
        end
      end

      if (event_mon.valid && event_mon.ready)
        awaited_answers.push_back(predict_answer(event_mon.bus_status, event_mon.rx_data));

      answers_outstanding <= awaited_answers.size();
    end
  end

endmodule

### tb/i2c_slave_motor_command_test.sv
`timescale 1ns / 1ps
// Top of the I2C slave motor command testbench: clock, reset, bus event and
// register stimulus, result-side stalls and the final verdict.
// Depends on imc_pkg, imc_channels, the block itself and imc_answer_checker.

module i2c_slave_motor_command_test;
  import imc_pkg::*;

  // Generous bound: well over a thousand events, each of which may wait out a
  // long sender gap and a long receiver stall, plus the register phases.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Random events per idling phase; three phases make up about 1150 events.
  localparam int unsigned PHASE_EVENTS = 385;
  // The block answers through its input and result registers; allow a margin.
  localparam int unsigned DRAIN_CYCLES = 8;
  // An index that names no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFC;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 72;
  int unsigned cycle_count = 0;
  int unsigned events_sent = 0;
  int          mismatch_count;
  int          answers_outstanding;

  imc_in_if  in_ch ();
  imc_out_if out_ch ();
  imc_cfg_if cfg_ch ();

  i2c_slave_motor_command DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // The checker sits beside the block and only watches the three channels.
  imc_answer_checker answer_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .event_mon           (in_ch),
    .answer_mon          (out_ch),
    .reg_mon             (cfg_ch),
    .mismatch_count      (mismatch_count),
    .answers_outstanding (answers_outstanding)
  );

  always #1 clk = ~clk;

  // The result side stalls at random at the rate of the current phase. With a
  // rate of zero it is always ready, which gives the stretches with no stalls.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one bus event after a random number of idle cycles and returns at
  // the edge where it was taken. Valid is left high, so that back-to-back
  // events go out without a bubble; whoever comes next decides whether it
  // drops. Every path drives valid at most once per time step.
  task automatic send_event(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.bus_status <= status;
    in_ch.rx_data    <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    events_sent++;
  endtask

  // Stops sending and waits until every answer the checker expects has come
  // back. The first edge lets the checker count the last transfer.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_outstanding != 0) @(posedge clk);
  endtask

  // One register write; like send_event it leaves valid high for the caller.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic open_loop, input logic [BYTE_W-1:0] r0,
                              input logic [BYTE_W-1:0] r1, input logic [BYTE_W-1:0] r2);
    write_reg(CFG_OPEN_LOOP, {7'($urandom_range(127)), open_loop});
    write_reg(CFG_REPLY_0, r0);
    write_reg(CFG_REPLY_1, r1);
    write_reg(CFG_REPLY_2, r2);
  endtask

  // A master write: addressed, a random number of data bytes (often past the
  // receive limit), sometimes a nacked byte, then a stop.
  task automatic write_burst();
    int unsigned n;
    n = $urandom_range(8);
    send_event(ST_SLA_W, 8'($urandom_range(255)));
    repeat (n) send_event(ST_DATA_RX, 8'($urandom_range(255)));
    if ($urandom_range(3) == 0) send_event(ST_DATA_RX_NA, 8'($urandom_range(255)));
    send_event(ST_STOP, 8'($urandom_range(255)));
  endtask

  // A master read: addressed, a random number of further bytes, which may run
  // past the end of the reply, then the last-byte status and sometimes a stop.
  task automatic read_burst();
    int unsigned n;
    n = $urandom_range(4);
    send_event(ST_SLA_R, 8'($urandom_range(255)));
    repeat (n) send_event(ST_DATA_TX, 8'($urandom_range(255)));
    send_event($urandom_range(1) ? ST_LAST_TX : ST_DATA_TX_NA, 8'($urandom_range(255)));
    if ($urandom_range(1)) send_event(ST_STOP, 8'($urandom_range(255)));
  endtask

  // Loose events that break the normal sequences: any status byte at all,
  // data or transmit events out of context, arbitration loss and bus errors.
  task automatic noise_event();
    case ($urandom_range(5))
      0:       send_event(ST_DATA_RX, 8'($urandom_range(255)));
      1:       send_event(ST_DATA_TX, 8'($urandom_range(255)));
      2:       send_event(ST_BUS_ERROR, 8'($urandom_range(255)));
      3:       send_event(ST_ARB_SLA_W, 8'($urandom_range(255)));
      default: send_event(8'($urandom_range(255)), 8'($urandom_range(255)));
    endcase
  endtask

  task automatic random_events(input int unsigned count);
    int unsigned first;
    first = events_sent;
    while (events_sent - first < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: write_burst();
        4, 5, 6:    read_burst();
        default:    noise_event();
      endcase
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.bus_status <= '0;
    in_ch.rx_data    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, still on the reset register values. A transmit event
    // before any read addressing must send the first reply byte.
    send_event(ST_DATA_TX, 8'hFF);
    send_event(ST_BUS_ERROR, 8'h00);
    send_event(8'h07, 8'hFF);
    send_event(8'hFF, 8'h00);
    settle();

    // Open-loop mode with the extreme reply values.
    program_regs(1'b1, 8'hFF, 8'h00, 8'h5A);
    cfg_ch.valid <= 1'b0;

    // First byte with both bits set: left motor, forward. The second byte
    // carries the largest duty, and the run goes on past the receive limit.
    send_event(ST_SLA_W, 8'h00);
    send_event(ST_DATA_RX, 8'h03);
    send_event(ST_DATA_RX, 8'hFF);
    repeat (4) send_event(ST_DATA_RX, 8'h00);
    send_event(ST_DATA_RX, 8'hAA);
    // First byte with both bits clear: right motor, backward, duty zero.
    send_event(ST_SLA_W, 8'hFF);
    send_event(ST_DATA_RX, 8'h00);
    send_event(ST_DATA_RX, 8'h00);
    send_event(ST_DATA_RX_NA, 8'h55);
    send_event(ST_STOP, 8'h00);
    send_event(ST_ARB_SLA_W, 8'h00);
    // A read that runs past the end of the reply.
    send_event(ST_SLA_R, 8'h00);
    repeat (4) send_event(ST_DATA_TX, 8'h00);
    send_event(ST_LAST_TX, 8'h00);
    send_event(ST_DATA_TX_NA, 8'h00);
    settle();

    // First idling phase: closed loop, then a write to an index that names no
    // register, whose data would turn open-loop mode on were it aliased.
    program_regs(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    write_reg(CFG_UNUSED, 8'hFF);
    cfg_ch.valid <= 1'b0;
    random_events(PHASE_EVENTS / 2);
    // The sender holds off here until every outstanding answer has arrived.
    settle();
    random_events(PHASE_EVENTS - PHASE_EVENTS / 2);
    settle();

    // Second phase: the roles swap, the sender now idles most of the time.
    send_idle_pct = 72;
    recv_idle_pct = 17;
    program_regs(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    cfg_ch.valid <= 1'b0;
    random_events(PHASE_EVENTS);
    settle();

    // Third phase: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(1'($urandom_range(1)), 8'h00, 8'hFF, 8'($urandom_range(255)));
    cfg_ch.valid <= 1'b0;
    random_events(PHASE_EVENTS);
    settle();

    // Give any stray result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && answers_outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hdl/imc_pkg.sv
hdl/imc_channels.sv
hdl/imc_cfg_regs.sv
hdl/imc_in_stage.sv
hdl/imc_decode.sv
hdl/imc_out_stage.sv
hdl/i2c_slave_motor_command.sv
tb/imc_answer_checker.sv
tb/i2c_slave_motor_command_test.sv
